>>> rtl/pcap_pkg.sv
package pcap_pkg;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 16;
  localparam int COMP_W  = 32;
  localparam int CIDX_W  = 3;

  // Beat layout
  localparam int S_TDATA_W = 24;  // index, value
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = COMP_W;
  localparam int M_TUSER_W = CIDX_W;

  // Arithmetic
  localparam int DIFF_W = VALUE_W + 1;       // sample minus mean
  localparam int PROD_W = DIFF_W + VALUE_W;  // diff times Q1.15 basis
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 15;

  // Configuration
  localparam int CFG_IDX_W = 1;
  localparam int VLEN_W    = 6;
  localparam int KDIMS_W   = 4;
  localparam int CFG_W     = VLEN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEPT_DIMS  = 1'b1;

  localparam logic [VLEN_W-1:0]  VLEN_RST  = 6'd32;
  localparam logic [KDIMS_W-1:0] KDIMS_RST = 4'd8;

  // Parameter defaults
  localparam int VEC_MAX_DEF = 32;
  localparam int OUT_MAX_DEF = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEAN   = 2'd0,
    KIND_BASIS  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic wr_mean;
    logic wr_basis;
    logic load_val;
    logic issue;
    logic out_load;
    logic acc_clear;
  } ctl_t;

endpackage

>>> rtl/pcap_store.sv
module pcap_store #(
  parameter int VEC_MAX = pcap_pkg::VEC_MAX_DEF,
  parameter int OUT_MAX = pcap_pkg::OUT_MAX_DEF,
  parameter int POS_W   = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1,
  parameter int ROW_W   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1
) (
  input  logic                                clk_i,
  input  pcap_pkg::ctl_t                      ctl_i,
  input  logic [pcap_pkg::INDEX_W-1:0]        wr_index_i,
  input  logic [pcap_pkg::VALUE_W-1:0]        wr_value_i,
  input  logic [POS_W-1:0]                    pos_i,
  input  logic [ROW_W-1:0]                    row_i,
  output logic signed [pcap_pkg::VALUE_W-1:0] mean_o,
  output logic signed [pcap_pkg::VALUE_W-1:0] basis_o
);

  localparam int BAS_DEPTH = VEC_MAX * OUT_MAX;
  localparam int BAS_AW    = (BAS_DEPTH > 1) ? $clog2(BAS_DEPTH) : 1;

  logic [pcap_pkg::VALUE_W-1:0] mean_mem  [VEC_MAX];
  logic [pcap_pkg::VALUE_W-1:0] basis_mem [BAS_DEPTH];

  logic [BAS_AW-1:0] bas_raddr;

  // row-major: row * VEC_MAX + column
  assign bas_raddr = BAS_AW'(32'(row_i) * 32'(VEC_MAX) + 32'(pos_i));

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_mean) begin
      mean_mem[POS_W'(wr_index_i)] <= wr_value_i;
    end
    if (ctl_i.issue) begin
      mean_o <= mean_mem[pos_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_basis) begin
      basis_mem[BAS_AW'(wr_index_i)] <= wr_value_i;
    end
    if (ctl_i.issue) begin
      basis_o <= basis_mem[bas_raddr];
    end
  end

endmodule

>>> rtl/pcap_mac.sv
module pcap_mac #(
  parameter int OUT_MAX = pcap_pkg::OUT_MAX_DEF,
  parameter int ROW_W   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcap_pkg::ctl_t                      ctl_i,
  input  logic [pcap_pkg::VALUE_W-1:0]        value_i,
  input  logic [ROW_W-1:0]                    row_i,
  input  logic                                last_i,
  input  logic signed [pcap_pkg::VALUE_W-1:0] mean_i,
  input  logic signed [pcap_pkg::VALUE_W-1:0] basis_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [pcap_pkg::COMP_W-1:0]         out_comp_o,
  output logic [pcap_pkg::CIDX_W-1:0]         out_cidx_o,
  output logic                                out_last_o,
  output logic                                out_free_o,
  output logic                                busy_o
);

  logic signed [pcap_pkg::VALUE_W-1:0] val_q;
  logic                                s1_vld_q, s2_vld_q;
  logic [ROW_W-1:0]                    s1_row_q, s2_row_q;
  logic signed [pcap_pkg::DIFF_W-1:0]  diff;
  logic signed [pcap_pkg::PROD_W-1:0]  prod_q;
  logic signed [pcap_pkg::ACC_W-1:0]   acc_q [OUT_MAX];
  logic signed [pcap_pkg::ACC_W-1:0]   acc_sh;
  logic                                out_valid_q, out_valid_d;
  logic [pcap_pkg::COMP_W-1:0]         comp_q;
  logic [pcap_pkg::CIDX_W-1:0]         cidx_q;
  logic                                last_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_val) begin
      val_q <= value_i;
    end
  end

  // stage 1: store data arrives, diff and multiply
  assign diff = pcap_pkg::DIFF_W'(val_q) - pcap_pkg::DIFF_W'(mean_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= ctl_i.issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= row_i;
    s2_row_q <= s1_row_q;
    prod_q   <= diff * basis_i;
  end

  // stage 2: accumulate, wraps mod 2^40
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < OUT_MAX; r++) begin
        acc_q[r] <= '0;
      end
    end else if (ctl_i.acc_clear) begin
      for (int r = 0; r < OUT_MAX; r++) begin
        acc_q[r] <= '0;
      end
    end else if (s2_vld_q) begin
      acc_q[s2_row_q] <= acc_q[s2_row_q] + pcap_pkg::ACC_W'(prod_q);
    end
  end

  // floor shift leaves 25 significant bits, so truncating to 32 bits loses nothing
  assign acc_sh = acc_q[row_i] >>> pcap_pkg::FRAC_W;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      comp_q <= pcap_pkg::COMP_W'(acc_sh);
      cidx_q <= pcap_pkg::CIDX_W'(row_i);
      last_q <= last_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_comp_o  = comp_q;
  assign out_cidx_o  = cidx_q;
  assign out_last_o  = last_q;
  assign out_free_o  = !out_valid_q || out_ready_i;
  assign busy_o      = s1_vld_q || s2_vld_q;

endmodule

>>> rtl/pcap_ctrl.sv
module pcap_ctrl #(
  parameter int VEC_MAX = pcap_pkg::VEC_MAX_DEF,
  parameter int OUT_MAX = pcap_pkg::OUT_MAX_DEF,
  parameter int POS_W   = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1,
  parameter int ROW_W   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcap_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcap_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic [pcap_pkg::KIND_W-1:0]     in_kind_i,
  input  logic [pcap_pkg::INDEX_W-1:0]    in_index_i,
  output logic                            in_ready_o,
  input  logic                            out_free_i,
  input  logic                            busy_i,
  output pcap_pkg::ctl_t                  ctl_o,
  output logic [POS_W-1:0]                pos_o,
  output logic [ROW_W-1:0]                row_o,
  output logic                            last_o
);

  pcap_pkg::state_e            state_q, state_d;
  logic [ROW_W-1:0]            row_q, row_d;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic                        end_q, end_d;
  logic [pcap_pkg::VLEN_W-1:0]  vlen_q;
  logic [pcap_pkg::KDIMS_W-1:0] kept_q;
  logic [ROW_W-1:0]            kd_m1;
  logic [31:0]                 len_eff;
  logic                        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= pcap_pkg::VLEN_RST;
      kept_q <= pcap_pkg::KDIMS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pcap_pkg::CFG_VECTOR_LEN: vlen_q <= cfg_wdata_i[pcap_pkg::VLEN_W-1:0];
        pcap_pkg::CFG_KEPT_DIMS:  kept_q <= cfg_wdata_i[pcap_pkg::KDIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers into 1..VEC_MAX and 1..OUT_MAX
  always_comb begin
    if (vlen_q == '0) begin
      len_eff = 32'd1;
    end else if (32'(vlen_q) > 32'(VEC_MAX)) begin
      len_eff = 32'(VEC_MAX);
    end else begin
      len_eff = 32'(vlen_q);
    end
    if (kept_q == '0) begin
      kd_m1 = '0;
    end else if (32'(kept_q) > 32'(OUT_MAX)) begin
      kd_m1 = ROW_W'(OUT_MAX - 1);
    end else begin
      kd_m1 = ROW_W'(kept_q - 1'b1);
    end
  end

  // ready is high only in idle
  assign accept = in_valid_i && (state_q == pcap_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    pos_d      = pos_q;
    end_d      = end_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pcap_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (pcap_pkg::kind_e'(in_kind_i))
            pcap_pkg::KIND_MEAN: begin
              ctl_o.wr_mean = 32'(in_index_i) < 32'(VEC_MAX);
            end
            pcap_pkg::KIND_BASIS: begin
              ctl_o.wr_basis = 32'(in_index_i) < 32'(VEC_MAX * OUT_MAX);
            end
            pcap_pkg::KIND_SAMPLE: begin
              ctl_o.load_val = 1'b1;
              row_d          = '0;
              end_d          = (32'(pos_q) + 32'd1) >= len_eff;
              state_d        = pcap_pkg::ST_MAC;
            end
            default: ;
          endcase
        end
      end
      pcap_pkg::ST_MAC: begin
        ctl_o.issue = 1'b1;
        if (row_q == kd_m1) begin
          state_d = pcap_pkg::ST_DRAIN;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      pcap_pkg::ST_DRAIN: begin
        if (!busy_i) begin
          row_d = '0;
          if (end_q) begin
            state_d = pcap_pkg::ST_EMIT;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = pcap_pkg::ST_IDLE;
          end
        end
      end
      pcap_pkg::ST_EMIT: begin
        if (out_free_i) begin
          ctl_o.out_load = 1'b1;
          if (row_q == kd_m1) begin
            ctl_o.acc_clear = 1'b1;
            pos_d           = '0;
            state_d         = pcap_pkg::ST_IDLE;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      default: state_d = pcap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcap_pkg::ST_IDLE;
      row_q   <= '0;
      pos_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
    end
  end

  assign pos_o  = pos_q;
  assign row_o  = row_q;
  assign last_o = row_q == kd_m1;

endmodule

>>> rtl/pca_projection_top.sv
// Mean-removed PCA projection.
// Input stream (s_axis): one beat per item. tuser carries the kind: load a mean
// element, load a basis entry (address row*VEC_MAX+column), or one sample element.
// Sample elements arrive in vector order; after vector_len of them the block sends
// kept_dims beats on m_axis, component 0 first, tlast on the final one.
// Each component is the sum of (sample - mean) * basis, floor-shifted right 15.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 vector_len, 1 kept_dims); write only while the block is idle.
// Sequence: a load beat is taken and the block stays idle. A sample beat is accepted,
// then each basis row in turn goes through the single shared multiplier
// (one mean/basis memory read per row), and then the block waits to drain the
// multiply/accumulate pipe (two stages, until the drain check sees it empty).
// The final element then sends one result per cycle while m_axis_tready is high.
// Reset: vector_len = 32, kept_dims = 8, accumulators and element position zero.
// Mean and basis memories hold garbage until loaded; no clearing pass.
// Stall: results sit in an output register; a stalled receiver holds emission,
// while the input side stays open once the last result of a vector is queued.
module pca_projection_top #(
  parameter int VEC_MAX = pcap_pkg::VEC_MAX_DEF,
  parameter int OUT_MAX = pcap_pkg::OUT_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcap_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcap_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pcap_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // index[7:0], value[23:8]
  input  logic [pcap_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // kind[1:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pcap_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // component[31:0]
  output logic [pcap_pkg::M_TUSER_W-1:0]   m_axis_tuser,  // component_index[2:0]
  output logic                             m_axis_tlast
);

  localparam int POS_W = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
  localparam int ROW_W = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

  pcap_pkg::ctl_t                      ctl;
  logic [POS_W-1:0]                    pos;
  logic [ROW_W-1:0]                    row;
  logic                                row_last;
  logic                                out_free;
  logic                                mac_busy;
  logic signed [pcap_pkg::VALUE_W-1:0] mean_rd;
  logic signed [pcap_pkg::VALUE_W-1:0] basis_rd;
  logic [pcap_pkg::INDEX_W-1:0]        in_index;
  logic [pcap_pkg::VALUE_W-1:0]        in_value;

  assign in_index = s_axis_tdata[pcap_pkg::INDEX_W-1:0];
  assign in_value = s_axis_tdata[pcap_pkg::INDEX_W +: pcap_pkg::VALUE_W];

  pcap_ctrl #(
    .VEC_MAX (VEC_MAX),
    .OUT_MAX (OUT_MAX),
    .POS_W   (POS_W),
    .ROW_W   (ROW_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_index_i  (in_index),
    .in_ready_o  (s_axis_tready),
    .out_free_i  (out_free),
    .busy_i      (mac_busy),
    .ctl_o       (ctl),
    .pos_o       (pos),
    .row_o       (row),
    .last_o      (row_last)
  );

  // mean and basis memories, one read each per multiply
  pcap_store #(
    .VEC_MAX (VEC_MAX),
    .OUT_MAX (OUT_MAX),
    .POS_W   (POS_W),
    .ROW_W   (ROW_W)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .wr_index_i (in_index),
    .wr_value_i (in_value),
    .pos_i      (pos),
    .row_i      (row),
    .mean_o     (mean_rd),
    .basis_o    (basis_rd)
  );

  // shared multiplier, accumulator bank and output register
  pcap_mac #(
    .OUT_MAX (OUT_MAX),
    .ROW_W   (ROW_W)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .value_i     (in_value),
    .row_i       (row),
    .last_i      (row_last),
    .mean_i      (mean_rd),
    .basis_i     (basis_rd),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_comp_o  (m_axis_tdata),
    .out_cidx_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_free_o  (out_free),
    .busy_o      (mac_busy)
  );

  // no input beat is taken while rows are being issued
  a_no_accept_in_mac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.issue |-> !s_axis_tready)
    else $error("input accepted during multiply issue");

  // results are read only after the last accumulate has landed
  a_emit_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> !mac_busy && !ctl.issue)
    else $error("result loaded while accumulate pipe busy");

  // accumulators clear when the final component is loaded into the output register
  a_clear_with_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.acc_clear |=> m_axis_tvalid && m_axis_tlast)
    else $error("accumulator clear without final component");

endmodule
